FILE: design/apcimon_pkg.sv
package apcimon_pkg;

  localparam int FlowIndexWidth   = 6;
  localparam int FlowIndexRange   = 1 << FlowIndexWidth;
  localparam int FlowCountDefault = 64;
  localparam int SeqWidth         = 15;
  localparam int UCodeWidth       = 6;
  localparam int PendWidth        = 6;

  localparam logic [SeqWidth-1:0] SeqHalf = 15'd16384;

  // U-format function bits
  localparam logic [UCodeWidth-1:0] UCodeStartAct = 6'd1;
  localparam logic [UCodeWidth-1:0] UCodeStartCon = 6'd2;
  localparam logic [UCodeWidth-1:0] UCodeStopAct  = 6'd4;
  localparam logic [UCodeWidth-1:0] UCodeStopCon  = 6'd8;
  localparam logic [UCodeWidth-1:0] UCodeTestAct  = 6'd16;
  localparam logic [UCodeWidth-1:0] UCodeTestCon  = 6'd32;

  localparam logic [1:0] UevNone      = 2'd0;
  localparam logic [1:0] UevAct       = 2'd1;
  localparam logic [1:0] UevConMatch  = 2'd2;
  localparam logic [1:0] UevConOrphan = 2'd3;

  localparam logic [1:0] FnStartdt = 2'd0;
  localparam logic [1:0] FnStopdt  = 2'd1;
  localparam logic [1:0] FnTestfr  = 2'd2;

  localparam logic [1:0] LinkUnknown = 2'd0;
  localparam logic [1:0] LinkStarted = 2'd1;
  localparam logic [1:0] LinkStopped = 2'd2;

  typedef struct packed {
    logic                  from_side;
    logic                  tx_present;
    logic [SeqWidth-1:0]   tx_seq;
    logic                  rx_present;
    logic [SeqWidth-1:0]   rx_seq;
    logic                  reordered;
    logic                  u_present;
    logic [UCodeWidth-1:0] u_code;
  } item_t;

  typedef struct packed {
    logic [1:0]           link_mode;
    logic [PendWidth-1:0] pending;
  } flow_rec_t;

  typedef struct packed {
    logic                tx_known;
    logic [SeqWidth-1:0] last_tx;
    logic                ack_known;
    logic [SeqWidth-1:0] last_ack;
    flow_rec_t           rec;
  } slot_rd_t;

  typedef struct packed {
    logic                tx_we;
    logic [SeqWidth-1:0] tx_seq;
    logic                ack_we;
    logic [SeqWidth-1:0] ack_seq;
    flow_rec_t           rec;
  } upd_t;

  typedef struct packed {
    logic                tx_gap;
    logic [SeqWidth-1:0] expected_tx;
    logic                data_after_stop;
    logic                ack_regression;
    logic                unknown_u;
    logic [1:0]          u_event;
    logic [1:0]          u_function;
    logic                duplicate_activation;
    logic [1:0]          link_mode_out;
  } result_t;

endpackage

FILE: design/apcimon_store.sv
module apcimon_store #(
  parameter int FLOW_DEPTH = apcimon_pkg::FlowCountDefault,
  localparam int FlowBits  = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [FlowBits-1:0]   rd_flow,
  input  logic                  rd_side,
  input  logic                  wr_en,
  input  logic [FlowBits-1:0]   wr_flow,
  input  logic                  wr_side,
  input  apcimon_pkg::upd_t     upd,
  output apcimon_pkg::slot_rd_t rd
);

  localparam int SlotDepth = 2 * FLOW_DEPTH;
  localparam int SlotBits  = FlowBits + 1;

  logic [apcimon_pkg::SeqWidth-1:0] tx_mem   [SlotDepth];
  logic [apcimon_pkg::SeqWidth-1:0] ack_mem  [SlotDepth];
  apcimon_pkg::flow_rec_t           flow_mem [FLOW_DEPTH];

  logic [SlotDepth-1:0]  tx_known_r;
  logic [SlotDepth-1:0]  ack_known_r;
  logic [FLOW_DEPTH-1:0] flow_vld_r;

  logic [apcimon_pkg::SeqWidth-1:0] tx_q_r;
  logic [apcimon_pkg::SeqWidth-1:0] ack_q_r;
  apcimon_pkg::flow_rec_t           rec_q_r;

  logic                             tx_byp_r;
  logic                             ack_byp_r;
  logic                             rec_byp_r;
  logic [apcimon_pkg::SeqWidth-1:0] tx_byp_val_r;
  logic [apcimon_pkg::SeqWidth-1:0] ack_byp_val_r;
  apcimon_pkg::flow_rec_t           rec_byp_val_r;

  logic [SlotBits-1:0] rd_slot;
  logic [SlotBits-1:0] wr_slot;

  assign rd_slot = {rd_flow, rd_side};
  assign wr_slot = {wr_flow, wr_side};

  always_ff @(posedge clk) begin
    if (wr_en && upd.tx_we) begin
      tx_mem[wr_slot] <= upd.tx_seq;
    end
    if (wr_en && upd.ack_we) begin
      ack_mem[wr_slot] <= upd.ack_seq;
    end
    if (wr_en) begin
      flow_mem[wr_flow] <= upd.rec;
    end
    if (rd_en) begin
      tx_q_r  <= tx_mem[rd_slot];
      ack_q_r <= ack_mem[rd_slot];
      rec_q_r <= flow_mem[rd_flow];
    end
  end

  // The memory read returns old data when the write stage updates the same
  // entry at the same edge: capture that write for the reading item.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tx_byp_r      <= wr_en && upd.tx_we && (wr_slot == rd_slot);
      ack_byp_r     <= wr_en && upd.ack_we && (wr_slot == rd_slot);
      rec_byp_r     <= wr_en && (wr_flow == rd_flow);
      tx_byp_val_r  <= upd.tx_seq;
      ack_byp_val_r <= upd.ack_seq;
      rec_byp_val_r <= upd.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_known_r  <= '0;
      ack_known_r <= '0;
      flow_vld_r  <= '0;
    end else if (wr_en) begin
      if (upd.tx_we) begin
        tx_known_r[wr_slot] <= 1'b1;
      end
      if (upd.ack_we) begin
        ack_known_r[wr_slot] <= 1'b1;
      end
      flow_vld_r[wr_flow] <= 1'b1;
    end
  end

  // Known and valid bits are read at the write-stage address; they are
  // current because only that stage writes them.
  always_comb begin
    rd.tx_known  = tx_known_r[wr_slot];
    rd.last_tx   = tx_byp_r ? tx_byp_val_r : tx_q_r;
    rd.ack_known = ack_known_r[wr_slot];
    rd.last_ack  = ack_byp_r ? ack_byp_val_r : ack_q_r;
    if (rec_byp_r) begin
      rd.rec = rec_byp_val_r;
    end else if (flow_vld_r[wr_flow]) begin
      rd.rec = rec_q_r;
    end else begin
      rd.rec = '0;
    end
  end

endmodule

FILE: design/apcimon_eval.sv
module apcimon_eval (
  input  apcimon_pkg::item_t    item,
  input  apcimon_pkg::slot_rd_t rd,
  output apcimon_pkg::result_t  res,
  output apcimon_pkg::upd_t     upd
);

  logic                             tx_chk;
  logic                             rx_chk;
  logic [apcimon_pkg::SeqWidth-1:0] exp_tx;
  logic [apcimon_pkg::SeqWidth-1:0] ack_diff;
  logic                             fn_known;
  logic                             is_act;
  logic [1:0]                       fn;
  logic [2:0]                       pend_idx;
  logic [apcimon_pkg::PendWidth-1:0] pend_bit;
  logic                             pend_hit;

  always_comb begin
    tx_chk   = item.tx_present && !item.reordered;
    rx_chk   = item.rx_present && !item.reordered;
    exp_tx   = rd.last_tx + 15'd1;
    ack_diff = item.rx_seq - rd.last_ack;

    fn_known = 1'b1;
    is_act   = 1'b0;
    fn       = apcimon_pkg::FnStartdt;
    case (item.u_code)
      apcimon_pkg::UCodeStartAct: begin fn = apcimon_pkg::FnStartdt; is_act = 1'b1; end
      apcimon_pkg::UCodeStopAct:  begin fn = apcimon_pkg::FnStopdt;  is_act = 1'b1; end
      apcimon_pkg::UCodeTestAct:  begin fn = apcimon_pkg::FnTestfr;  is_act = 1'b1; end
      apcimon_pkg::UCodeStartCon: fn = apcimon_pkg::FnStartdt;
      apcimon_pkg::UCodeStopCon:  fn = apcimon_pkg::FnStopdt;
      apcimon_pkg::UCodeTestCon:  fn = apcimon_pkg::FnTestfr;
      default: fn_known = 1'b0;
    endcase

    // activations mark the sender's bit, confirmations clear the peer's
    pend_idx = ((item.from_side ^ !is_act) ? 3'd3 : 3'd0) + {1'b0, fn};
    pend_bit = 6'd1 << pend_idx;
    pend_hit = |(rd.rec.pending & pend_bit);

    res = '0;
    upd.tx_we   = tx_chk;
    upd.tx_seq  = item.tx_seq;
    upd.ack_we  = rx_chk;
    upd.ack_seq = item.rx_seq;
    upd.rec     = rd.rec;

    if (tx_chk) begin
      if (rd.tx_known && (item.tx_seq != exp_tx)) begin
        res.tx_gap      = 1'b1;
        res.expected_tx = exp_tx;
      end
      res.data_after_stop = (rd.rec.link_mode == apcimon_pkg::LinkStopped);
    end

    res.ack_regression = rx_chk && rd.ack_known && (ack_diff > apcimon_pkg::SeqHalf);

    if (item.u_present) begin
      if (!fn_known) begin
        res.unknown_u = 1'b1;
      end else begin
        res.u_function = fn;
        if (is_act) begin
          res.duplicate_activation = pend_hit;
          res.u_event              = apcimon_pkg::UevAct;
          upd.rec.pending          = rd.rec.pending | pend_bit;
        end else begin
          if (pend_hit) begin
            res.u_event     = apcimon_pkg::UevConMatch;
            upd.rec.pending = rd.rec.pending & ~pend_bit;
          end else begin
            res.u_event = apcimon_pkg::UevConOrphan;
          end
          if (fn == apcimon_pkg::FnStartdt) begin
            upd.rec.link_mode = apcimon_pkg::LinkStarted;
          end else if (fn == apcimon_pkg::FnStopdt) begin
            upd.rec.link_mode = apcimon_pkg::LinkStopped;
          end
        end
      end
    end

    res.link_mode_out = upd.rec.link_mode;
  end

endmodule

FILE: design/iec104_apci_sequence_monitor.sv
// IEC 104 APCI sequence monitor. Takes one observed frame per cycle while
// in_ready is high and returns one result per frame via the check-stage and
// output registers. Per-flow and per-side state (last send and acknowledge
// numbers, link mode, pending U activations) sits in memories that are read
// at acceptance and written when the frame leaves the check stage; a bypass
// from that write covers back-to-back frames of the same flow. Reset takes
// effect at once through per-entry valid bits: no clearing pass is needed.
// Flow indexes at or above FLOW_COUNT wrap modulo FLOW_COUNT.
module iec104_apci_sequence_monitor #(
  parameter int FLOW_COUNT = apcimon_pkg::FlowCountDefault
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [apcimon_pkg::FlowIndexWidth-1:0] in_flow_index,
  input  logic                                 in_from_side,
  input  logic                                 in_tx_present,
  input  logic [apcimon_pkg::SeqWidth-1:0]     in_tx_seq,
  input  logic                                 in_rx_present,
  input  logic [apcimon_pkg::SeqWidth-1:0]     in_rx_seq,
  input  logic                                 in_reordered,
  input  logic                                 in_u_present,
  input  logic [apcimon_pkg::UCodeWidth-1:0]   in_u_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_tx_gap,
  output logic [apcimon_pkg::SeqWidth-1:0]     out_expected_tx,
  output logic                                 out_data_after_stop,
  output logic                                 out_ack_regression,
  output logic                                 out_unknown_u,
  output logic [1:0]                           out_u_event,
  output logic [1:0]                           out_u_function,
  output logic                                 out_duplicate_activation,
  output logic [1:0]                           out_link_mode_out
);

  localparam int FlowDepth = (FLOW_COUNT < apcimon_pkg::FlowIndexRange) ?
                             FLOW_COUNT : apcimon_pkg::FlowIndexRange;
  localparam int FlowBits  = (FlowDepth > 1) ? $clog2(FlowDepth) : 1;

  logic [FlowBits-1:0] wrap_tab [apcimon_pkg::FlowIndexRange];

  genvar gi;
  generate
    for (gi = 0; gi < apcimon_pkg::FlowIndexRange; gi++) begin : g_wrap
      assign wrap_tab[gi] = FlowBits'(gi % FLOW_COUNT);
    end
  endgenerate

  logic                  s1_valid_r, s1_valid_nxt;
  apcimon_pkg::item_t    s1_item_r;
  logic [FlowBits-1:0]   s1_flow_r;
  logic                  out_valid_r, out_valid_nxt;
  apcimon_pkg::result_t  out_res_r;

  logic                  accept;
  logic                  s1_fire;
  logic [FlowBits-1:0]   in_flow;
  apcimon_pkg::item_t    in_item;
  apcimon_pkg::slot_rd_t rd;
  apcimon_pkg::result_t  res;
  apcimon_pkg::upd_t     upd;

  assign in_flow = wrap_tab[in_flow_index];

  always_comb begin
    in_item.from_side  = in_from_side;
    in_item.tx_present = in_tx_present;
    in_item.tx_seq     = in_tx_seq;
    in_item.rx_present = in_rx_present;
    in_item.rx_seq     = in_rx_seq;
    in_item.reordered  = in_reordered;
    in_item.u_present  = in_u_present;
    in_item.u_code     = in_u_code;
  end

  assign s1_fire       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_fire;
  assign accept        = in_valid && in_ready;
  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
      s1_flow_r <= in_flow;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  apcimon_store #(
    .FLOW_DEPTH(FlowDepth)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_flow (in_flow),
    .rd_side (in_from_side),
    .wr_en   (s1_fire),
    .wr_flow (s1_flow_r),
    .wr_side (s1_item_r.from_side),
    .upd     (upd),
    .rd      (rd)
  );

  apcimon_eval u_eval (
    .item (s1_item_r),
    .rd   (rd),
    .res  (res),
    .upd  (upd)
  );

  assign out_valid                = out_valid_r;
  assign out_tx_gap               = out_res_r.tx_gap;
  assign out_expected_tx          = out_res_r.expected_tx;
  assign out_data_after_stop      = out_res_r.data_after_stop;
  assign out_ack_regression       = out_res_r.ack_regression;
  assign out_unknown_u            = out_res_r.unknown_u;
  assign out_u_event              = out_res_r.u_event;
  assign out_u_function           = out_res_r.u_function;
  assign out_duplicate_activation = out_res_r.duplicate_activation;
  assign out_link_mode_out        = out_res_r.link_mode_out;

`ifndef SYNTHESIS
  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (out_valid_r && !out_ready))
    else $error("check stage stalled with output register free");

  a_expected_only_on_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.tx_gap) |-> (out_res_r.expected_tx == '0))
    else $error("expected send number without a gap");

  a_function_only_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.u_event == apcimon_pkg::UevNone)) |->
    (out_res_r.u_function == apcimon_pkg::FnStartdt && !out_res_r.duplicate_activation))
    else $error("U function reported without a U event");

  a_unknown_excludes_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.unknown_u) |-> (out_res_r.u_event == apcimon_pkg::UevNone))
    else $error("unknown U code paired");
`endif

endmodule
